/* hdl/lrps_pkg.sv */
// ----------------------------------------------------------------------------
// Lamp ramp controller package
// Shared payload types and phase codes for the lamp ramp and shutdown block.
// ----------------------------------------------------------------------------
package lrps_pkg;

   localparam int LEVEL_W = 8;
   localparam int COUNT_W = 14;
   localparam int CSR_W   = 14;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_FULL_LEVEL       = 2'd0,
      CSR_DIM_LEVEL        = 2'd1,
      CSR_SHUTDOWN_TICKS   = 2'd2,
      CSR_FULL_ON_SHUTDOWN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_RUN   = 2'd0,
      PH_COUNT = 2'd1,
      PH_RAMP  = 2'd2,
      PH_HALT  = 2'd3
   } phase_type;

   typedef enum logic {
      KIND_CONTROL = 1'b0,
      KIND_PWM     = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     headlights_on;
      logic     park_selected;
      logic     ignition_on;
   } req_type;

   typedef struct packed {
      logic               lamp_out;
      logic               power_hold;
      logic [LEVEL_W-1:0] level;
      phase_type          phase;
   } rsp_type;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET     = 8'd255;
   localparam logic [LEVEL_W-1:0] DIM_LEVEL_RESET      = 8'd128;
   localparam logic [COUNT_W-1:0] SHUTDOWN_TICKS_RESET = 14'd10000;

endpackage

/* hdl/lamp_ramp_pwm_shutdown_controller.sv */
// ----------------------------------------------------------------------------
// Lamp ramp, PWM and shutdown controller
// Daytime lamp brightness ramp with PWM drive and delayed power-down.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req_ channel is one tick: a control tick (kind 0)
// ramps the brightness one step towards its target and runs the
// ignition-off countdown, a PWM tick (kind 1) advances the 8-bit PWM
// counter, which latches the duty at wrap and drives the lamp pin.
// Every request produces exactly one transfer on the rsp_ channel carrying
// the lamp pin, the power latch, the ramped level and the phase after that
// tick.
// The response is held in an output register in the cycle after the request
// transfer. Throughput is one item per clock while the receiver keeps taking
// responses; the whole state update is a single pass of short logic from the
// state registers into the state and response registers.
// A new request is taken while a response is still waiting, as long as the
// receiver takes that response in the same cycle; when the receiver stalls,
// req_ready falls and the held response stays unchanged.
// The csr_ port writes the four settings; it is to be used while the block
// is idle, which the block does not enforce. Synchronous reset restores the
// default settings, clears the brightness, PWM and countdown state, returns
// to the running phase with the power latch set, and empties the response
// register. Once halted, the block state holds until reset.
// ----------------------------------------------------------------------------
module lamp_ramp_pwm_shutdown_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lrps_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lrps_pkg::rsp_type            rsp_data,
   input  logic                         csr_write_enable,
   input  lrps_pkg::csr_index_type      csr_index,
   input  logic [lrps_pkg::CSR_W-1:0]   csr_write_data
);
   import lrps_pkg::*;

   // Settings
   logic [LEVEL_W-1:0] full_level_ff;
   logic [LEVEL_W-1:0] dim_level_ff;
   logic [COUNT_W-1:0] shutdown_ticks_ff;
   logic               full_on_shutdown_ff;

   // Block state and its next values
   logic [LEVEL_W-1:0] bright_ff,   bright_in;
   logic [COUNT_W-1:0] countdown_ff, countdown_in;
   phase_type          mode_ff,     mode_in;
   logic [LEVEL_W-1:0] pwm_count_ff, pwm_count_in;
   logic [LEVEL_W-1:0] duty_ff,     duty_in;
   logic               lamp_ff,     lamp_in;
   logic               hold_ff,     hold_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;

   logic               req_take;
   logic [LEVEL_W-1:0] target;

   // A request is taken whenever the response register is empty or is
   // being emptied in this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state for one tick. The steps follow one another in the same
   // order as the behaviour requires, all on narrow values.
   always_comb begin
      bright_in    = bright_ff;
      countdown_in = countdown_ff;
      mode_in      = mode_ff;
      pwm_count_in = pwm_count_ff;
      duty_in      = duty_ff;
      lamp_in      = lamp_ff;
      hold_in      = hold_ff;
      target       = req_data.headlights_on ? '0 :
                     (req_data.park_selected ? dim_level_ff : full_level_ff);

      if (req_take && mode_ff != PH_HALT) begin
         if (req_data.kind == KIND_PWM) begin
            pwm_count_in = pwm_count_ff + 1'b1;
            if (pwm_count_in == '0) begin
               duty_in = bright_ff;
               lamp_in = 1'b1;
            end
            if (pwm_count_in == duty_in) begin
               lamp_in = 1'b0;
            end
         end else if (mode_ff == PH_RAMP) begin
            if (bright_ff != '0) begin
               bright_in = bright_ff - 1'b1;
            end
            if (bright_in == '0) begin
               mode_in = PH_HALT;
               lamp_in = 1'b0;
               hold_in = 1'b0;
            end
         end else begin
            if (!req_data.ignition_on) begin
               if (mode_ff == PH_RUN) begin
                  countdown_in = shutdown_ticks_ff;
                  mode_in      = PH_COUNT;
               end
               if (full_on_shutdown_ff) begin
                  target = full_level_ff;
               end
            end else if (mode_ff == PH_COUNT) begin
               mode_in = PH_RUN;
            end

            if (target > bright_ff) begin
               bright_in = bright_ff + 1'b1;
            end else if (target < bright_ff) begin
               bright_in = bright_ff - 1'b1;
            end

            // Countdown runs after the brightness step; on expiry the first
            // ramp-down step is taken in the same tick.
            if (mode_in == PH_COUNT) begin
               if (countdown_in != '0) begin
                  countdown_in = countdown_in - 1'b1;
               end
               if (countdown_in == '0) begin
                  mode_in = PH_RAMP;
                  if (bright_in != '0) begin
                     bright_in = bright_in - 1'b1;
                  end
                  if (bright_in == '0) begin
                     mode_in = PH_HALT;
                     lamp_in = 1'b0;
                     hold_in = 1'b0;
                  end
               end
            end
         end
      end

      rsp_data_in.lamp_out   = lamp_in;
      rsp_data_in.power_hold = hold_in;
      rsp_data_in.level      = bright_in;
      rsp_data_in.phase      = mode_in;

      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff       <= FULL_LEVEL_RESET;
         dim_level_ff        <= DIM_LEVEL_RESET;
         shutdown_ticks_ff   <= SHUTDOWN_TICKS_RESET;
         full_on_shutdown_ff <= 1'b1;
         bright_ff           <= '0;
         countdown_ff        <= '0;
         mode_ff             <= PH_RUN;
         pwm_count_ff        <= '0;
         duty_ff             <= '0;
         lamp_ff             <= 1'b0;
         hold_ff             <= 1'b1;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FULL_LEVEL: begin
                  full_level_ff <= csr_write_data[LEVEL_W-1:0];
               end
               CSR_DIM_LEVEL: begin
                  dim_level_ff <= csr_write_data[LEVEL_W-1:0];
               end
               CSR_SHUTDOWN_TICKS: begin
                  shutdown_ticks_ff <= csr_write_data[COUNT_W-1:0];
               end
               CSR_FULL_ON_SHUTDOWN: begin
                  full_on_shutdown_ff <= csr_write_data[0];
               end
               default: begin
               end
            endcase
         end
         bright_ff    <= bright_in;
         countdown_ff <= countdown_in;
         mode_ff      <= mode_in;
         pwm_count_ff <= pwm_count_in;
         duty_ff      <= duty_in;
         lamp_ff      <= lamp_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The response payload is only loaded with a request transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // Once halted, the block stays halted until reset.
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      mode_ff == PH_HALT |=> mode_ff == PH_HALT)
      else $error("halted phase left without reset");

   // A halted block drives neither the lamp nor the power latch.
   a_halt_pins_clear: assert property (@(posedge clock) disable iff (reset)
      mode_ff == PH_HALT |-> !lamp_ff && !hold_ff && bright_ff == '0)
      else $error("pins or level not clear while halted");

   // An expired countdown always leaves the counting phase in the same tick.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == PH_COUNT |-> countdown_ff != '0)
      else $error("counting phase with an expired countdown");

   // Every request transfer yields a response in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("request transfer without a response");
`endif

endmodule
